// ----- design/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, widths, register indexes and the control store of the
// microcoded sequencer that plays a PWM level pattern with optional fade.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Default depth of the step tables.
  localparam int MAX_STEPS_DEF = 16;

  // Field widths.
  localparam int LVL_W = 8;
  localparam int DUR_W = 16;
  localparam int ACC_W = LVL_W + DUR_W;
  localparam int CFG_W = 16;
  localparam int UPC_W = 5;

  // Request codes carried by an input item.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP_COUNT   = 2'd0;
  localparam logic [1:0] REG_REPEAT_COUNT = 2'd1;
  localparam logic [1:0] REG_FADE_ENABLE  = 2'd2;
  localparam logic [1:0] REG_UPDATE_INTVL = 2'd3;

  // Input item.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [3:0]       step_index;
    logic [LVL_W-1:0] step_level;
    logic [DUR_W-1:0] step_duration;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [LVL_W-1:0] pwm_level;
    logic             level_written;
    logic             is_playing;
  } out_t;

  // Datapath operation of one microstep.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_WRITE,
    OP_START_INIT,
    OP_START_LOAD,
    OP_TICK,
    OP_CUR_INC,
    OP_WRAP,
    OP_LOAD_ADV,
    OP_STOP,
    OP_CLR_SINCE,
    OP_LATCH0,
    OP_LATCH1,
    OP_MUL0,
    OP_MUL1,
    OP_DIV_GO,
    OP_LOAD_Q,
    OP_LOAD_L1,
    OP_LOAD_L0,
    OP_EMIT
  } op_t;

  // Table read issued by a microstep; the read data comes from a registered port.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_ZERO,
    RD_CUR,
    RD_NEXT
  } rd_t;

  // Jump condition; when it is false the step counter moves on by one.
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_INACTIVE,
    C_FADE,
    C_TL_NZ,
    C_CUR_LT_CNT,
    C_PASS_EQ,
    C_SINCE_LT,
    C_LAST,
    C_DUR_ZERO,
    C_DIV_BUSY,
    C_OVERDUE
  } cond_t;

  typedef logic [UPC_W-1:0] upc_t;

  // One control word.
  typedef struct packed {
    op_t   op;
    rd_t   rd;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Control store addresses.
  localparam upc_t U_IDLE = 5'd0;
  localparam upc_t U_WR   = 5'd1;
  localparam upc_t U_ST0  = 5'd2;
  localparam upc_t U_ST1  = 5'd3;
  localparam upc_t U_TK0  = 5'd4;
  localparam upc_t U_TK1  = 5'd5;
  localparam upc_t U_NF0  = 5'd6;
  localparam upc_t U_ADV0 = 5'd7;
  localparam upc_t U_ADV1 = 5'd8;
  localparam upc_t U_ADV2 = 5'd9;
  localparam upc_t U_ADV3 = 5'd10;
  localparam upc_t U_ADV4 = 5'd11;
  localparam upc_t U_ADV5 = 5'd12;
  localparam upc_t U_STOP = 5'd13;
  localparam upc_t U_FD0  = 5'd14;
  localparam upc_t U_FD1  = 5'd15;
  localparam upc_t U_FD2  = 5'd16;
  localparam upc_t U_FD3  = 5'd17;
  localparam upc_t U_FD4  = 5'd18;
  localparam upc_t U_FD5  = 5'd19;
  localparam upc_t U_FD6  = 5'd20;
  localparam upc_t U_FD7  = 5'd21;
  localparam upc_t U_FD8  = 5'd22;
  localparam upc_t U_FZ   = 5'd23;
  localparam upc_t U_FL0  = 5'd24;
  localparam upc_t U_FOV  = 5'd25;
  localparam upc_t U_END  = 5'd26;

  // Entry point of the program for each request code.
  function automatic upc_t entry(input logic [1:0] req);
    upc_t e;
    unique case (req)
      REQ_TICK:  e = U_TK0;
      REQ_WRITE: e = U_WR;
      REQ_START: e = U_ST0;
      REQ_NONE:  e = U_END;
      default:   e = U_END;
    endcase
    return e;
  endfunction

  // Control store contents.
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    unique case (addr)
      // Table write.
      U_WR:   w = '{OP_WRITE,      RD_NONE, C_ALWAYS,     U_END};
      // Start: clear counters, then drive step 0.
      U_ST0:  w = '{OP_START_INIT, RD_ZERO, C_NEXT,       U_IDLE};
      U_ST1:  w = '{OP_START_LOAD, RD_NONE, C_ALWAYS,     U_END};
      // Tick: count time, then branch on fade mode.
      U_TK0:  w = '{OP_TICK,       RD_NONE, C_INACTIVE,   U_END};
      U_TK1:  w = '{OP_NOP,        RD_NONE, C_FADE,       U_FD0};
      U_NF0:  w = '{OP_NOP,        RD_NONE, C_TL_NZ,      U_END};
      // Step advance, shared by both modes.
      U_ADV0: w = '{OP_CUR_INC,    RD_NONE, C_NEXT,       U_IDLE};
      U_ADV1: w = '{OP_NOP,        RD_NONE, C_CUR_LT_CNT, U_ADV4};
      U_ADV2: w = '{OP_NOP,        RD_NONE, C_PASS_EQ,    U_STOP};
      U_ADV3: w = '{OP_WRAP,       RD_NONE, C_NEXT,       U_IDLE};
      U_ADV4: w = '{OP_NOP,        RD_CUR,  C_NEXT,       U_IDLE};
      U_ADV5: w = '{OP_LOAD_ADV,   RD_NONE, C_ALWAYS,     U_END};
      U_STOP: w = '{OP_STOP,       RD_NONE, C_ALWAYS,     U_END};
      // Fade refresh.
      U_FD0:  w = '{OP_NOP,        RD_NONE, C_SINCE_LT,   U_END};
      U_FD1:  w = '{OP_CLR_SINCE,  RD_CUR,  C_LAST,       U_FL0};
      U_FD2:  w = '{OP_LATCH0,     RD_NEXT, C_NEXT,       U_IDLE};
      U_FD3:  w = '{OP_LATCH1,     RD_NONE, C_DUR_ZERO,   U_FZ};
      U_FD4:  w = '{OP_MUL0,       RD_NONE, C_NEXT,       U_IDLE};
      U_FD5:  w = '{OP_MUL1,       RD_NONE, C_NEXT,       U_IDLE};
      U_FD6:  w = '{OP_DIV_GO,     RD_NONE, C_NEXT,       U_IDLE};
      U_FD7:  w = '{OP_NOP,        RD_NONE, C_DIV_BUSY,   U_FD7};
      U_FD8:  w = '{OP_LOAD_Q,     RD_NONE, C_ALWAYS,     U_FOV};
      U_FZ:   w = '{OP_LOAD_L1,    RD_NONE, C_ALWAYS,     U_FOV};
      U_FL0:  w = '{OP_LOAD_L0,    RD_NONE, C_NEXT,       U_IDLE};
      U_FOV:  w = '{OP_NOP,        RD_NONE, C_OVERDUE,    U_ADV0};
      // Result.
      U_END:  w = '{OP_EMIT,       RD_NONE, C_ALWAYS,     U_IDLE};
      default: w = '{OP_NOP,       RD_NONE, C_ALWAYS,     U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- design/lps_div.sv -----
// ----------------------------------------------------------------------------
// LED pattern sequencer divider
// Restoring divider for the fade level. The quotient is known to be below
// 256, so eight steps of one bit each produce it.
// ----------------------------------------------------------------------------
module lps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [lps_pkg::ACC_W-1:0]   num,
  input  logic [lps_pkg::DUR_W-1:0]   den,
  output logic                        busy,
  output logic [lps_pkg::LVL_W-1:0]   quo
);

  localparam int LW = lps_pkg::LVL_W;
  localparam int DW = lps_pkg::DUR_W;
  localparam int NW = $clog2(LW + 1);

  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] sh_r, sh_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One quotient bit per cycle: shift in the next dividend bit, subtract.
  always_comb begin
    trial   = {rem_r, sh_r[LW-1]};
    diff    = trial - {1'b0, den};
    ge      = (trial >= {1'b0, den});
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    if (go) begin
      cnt_nxt = NW'(LW);
      rem_nxt = num[lps_pkg::ACC_W-1:LW];
      sh_nxt  = num[LW-1:0];
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_nxt  = {sh_r[LW-2:0], ge};
    end
  end

  // The step counter is control state; the working registers need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = sh_r;

endmodule

// ----- design/led_pattern_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Plays a table of (level, duration) steps on a PWM level, with optional
// linear fade between steps, under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done, and the result appears on out_item for exactly one
// cycle with out_valid high, in the first cycle in which busy is low again.
// The receiver cannot stall, so it must take the result in that cycle. A new
// item may be started in the same cycle in which the previous result is
// shown. A tick that does a fade refresh with interpolation and then
// advances an overdue step takes the longest; the time an item takes is set
// by the microprogram stepping one control word per cycle and, for the
// interpolation, by the divider that forms the interpolated level one bit
// per cycle, which the program waits for. Configuration writes take effect
// at once and should be made only while the block idles.
module led_pattern_sequencer_unit #(
  parameter int MAX_STEPS = lps_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Item channel
  input  logic                        start,
  output logic                        busy,
  input  lps_pkg::in_t                in_item,
  // Result channel
  output logic                        out_valid,
  output lps_pkg::out_t               out_item,
  // Configuration port
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]   cfg_data
);

  localparam int LW = lps_pkg::LVL_W;
  localparam int DW = lps_pkg::DUR_W;
  localparam int MW = lps_pkg::ACC_W;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int AW = $clog2(MAX_STEPS);

  // Configuration registers.
  logic [4:0]    step_count_r;
  logic [7:0]    repeat_count_r;
  logic          fade_enable_r;
  logic [DW-1:0] update_intvl_r;

  // Sequencer.
  lps_pkg::upc_t   upc_r, upc_nxt;
  lps_pkg::uword_t uw;
  logic            accept;
  logic            cond_true;

  // Playback state.
  logic [CW-1:0] cur_r, cur_nxt;
  logic [7:0]    passes_r, passes_nxt;
  logic [DW-1:0] tl_r, tl_nxt;
  logic [DW-1:0] since_r, since_nxt;
  logic          active_r, active_nxt;
  logic [LW-1:0] held_r, held_nxt;

  // Working registers of one item.
  lps_pkg::in_t  req_r;
  logic          wrote_r, wrote_nxt;
  logic          overdue_r, overdue_nxt;
  logic [LW-1:0] l0_r, l0_nxt;
  logic [LW-1:0] l1_r, l1_nxt;
  logic [DW-1:0] dur_r, dur_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] acc_r, acc_nxt;

  // Step tables and their registered read port.
  logic [LW-1:0] lvl_mem [MAX_STEPS];
  logic [DW-1:0] dur_mem [MAX_STEPS];
  logic [LW-1:0] rd_level_r;
  logic [DW-1:0] rd_dur_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // Derived values.
  logic [CW-1:0] eff_cnt;
  logic [CW:0]   cur_plus1;
  logic [LW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic [MW-1:0] product;

  // Result registers.
  logic          out_valid_r;
  lps_pkg::out_t out_r;

  // Divider.
  logic          div_go;
  logic          div_busy;
  logic [LW-1:0] div_quo;

  // Clamp a step number onto the table.
  function automatic logic [AW-1:0] slot(input logic [CW:0] v);
    logic [AW-1:0] s;
    if (32'(v) < 32'(MAX_STEPS)) begin
      s = AW'(v);
    end else begin
      s = AW'(MAX_STEPS - 1);
    end
    return s;
  endfunction

  // Step count in use: zero acts as one, large values as the table depth.
  always_comb begin
    if (step_count_r == '0) begin
      eff_cnt = CW'(1);
    end else if (32'(step_count_r) > 32'(MAX_STEPS)) begin
      eff_cnt = CW'(MAX_STEPS);
    end else begin
      eff_cnt = CW'(step_count_r);
    end
  end

  assign cur_plus1 = {1'b0, cur_r} + 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r   <= 5'd1;
      repeat_count_r <= '0;
      fade_enable_r  <= 1'b0;
      update_intvl_r <= DW'(20);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lps_pkg::REG_STEP_COUNT:   step_count_r   <= cfg_data[4:0];
        lps_pkg::REG_REPEAT_COUNT: repeat_count_r <= cfg_data[7:0];
        lps_pkg::REG_FADE_ENABLE:  fade_enable_r  <= cfg_data[0];
        lps_pkg::REG_UPDATE_INTVL: update_intvl_r <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Control word and jump condition.
  assign uw     = lps_pkg::ucode(upc_r);
  assign busy   = (upc_r != lps_pkg::U_IDLE);
  assign accept = start && !busy;

  always_comb begin
    unique case (uw.cond)
      lps_pkg::C_NEXT:       cond_true = 1'b0;
      lps_pkg::C_ALWAYS:     cond_true = 1'b1;
      lps_pkg::C_INACTIVE:   cond_true = !active_r;
      lps_pkg::C_FADE:       cond_true = fade_enable_r;
      lps_pkg::C_TL_NZ:      cond_true = (tl_r != '0);
      lps_pkg::C_CUR_LT_CNT: cond_true = (cur_r < eff_cnt);
      lps_pkg::C_PASS_EQ:    cond_true = (passes_r == repeat_count_r);
      lps_pkg::C_SINCE_LT:   cond_true = (since_r < update_intvl_r);
      lps_pkg::C_LAST:       cond_true = (cur_plus1 >= {1'b0, eff_cnt});
      lps_pkg::C_DUR_ZERO:   cond_true = (dur_r == '0);
      lps_pkg::C_DIV_BUSY:   cond_true = div_busy;
      lps_pkg::C_OVERDUE:    cond_true = overdue_r;
      default:               cond_true = 1'b0;
    endcase
  end

  // Step counter: dispatch on the request code, then follow the program.
  always_comb begin
    if (upc_r == lps_pkg::U_IDLE) begin
      upc_nxt = start ? lps_pkg::entry(in_item.req_type) : lps_pkg::U_IDLE;
    end else if (cond_true) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  // Shared multiplier for the two interpolation products.
  assign mul_a   = (uw.op == lps_pkg::OP_MUL0) ? l0_r : l1_r;
  assign mul_b   = (uw.op == lps_pkg::OP_MUL0) ? rem_r : (dur_r - rem_r);
  assign product = MW'(mul_a) * MW'(mul_b);

  // Datapath: each control word selects one operation.
  always_comb begin
    cur_nxt     = cur_r;
    passes_nxt  = passes_r;
    tl_nxt      = tl_r;
    since_nxt   = since_r;
    active_nxt  = active_r;
    held_nxt    = held_r;
    wrote_nxt   = accept ? 1'b0 : wrote_r;
    overdue_nxt = overdue_r;
    l0_nxt      = l0_r;
    l1_nxt      = l1_r;
    dur_nxt     = dur_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    unique case (uw.op)
      lps_pkg::OP_NOP, lps_pkg::OP_WRITE, lps_pkg::OP_DIV_GO,
      lps_pkg::OP_EMIT: ;
      lps_pkg::OP_START_INIT: begin
        cur_nxt    = '0;
        passes_nxt = '0;
        active_nxt = 1'b1;
      end
      lps_pkg::OP_START_LOAD: begin
        held_nxt  = rd_level_r;
        tl_nxt    = rd_dur_r;
        wrote_nxt = 1'b1;
      end
      lps_pkg::OP_TICK: begin
        if (since_r != '1) begin
          since_nxt = since_r + 1'b1;
        end
        overdue_nxt = (tl_r == '0);
        if (tl_r != '0) begin
          tl_nxt = tl_r - 1'b1;
        end
      end
      lps_pkg::OP_CUR_INC: begin
        cur_nxt = cur_r + 1'b1;
      end
      lps_pkg::OP_WRAP: begin
        passes_nxt = passes_r + 1'b1;
        cur_nxt    = '0;
      end
      lps_pkg::OP_LOAD_ADV: begin
        tl_nxt = rd_dur_r;
        // Without fade a step change drives the new step's level.
        if (!fade_enable_r) begin
          held_nxt  = rd_level_r;
          wrote_nxt = 1'b1;
        end
      end
      lps_pkg::OP_STOP: begin
        active_nxt = 1'b0;
      end
      lps_pkg::OP_CLR_SINCE: begin
        since_nxt = '0;
        wrote_nxt = 1'b1;
      end
      lps_pkg::OP_LATCH0: begin
        l0_nxt  = rd_level_r;
        dur_nxt = rd_dur_r;
        // Remaining time beyond the step's duration counts as the duration.
        rem_nxt = (tl_r > rd_dur_r) ? rd_dur_r : tl_r;
      end
      lps_pkg::OP_LATCH1: begin
        l1_nxt = rd_level_r;
      end
      lps_pkg::OP_MUL0: begin
        acc_nxt = product;
      end
      lps_pkg::OP_MUL1: begin
        acc_nxt = acc_r + product;
      end
      lps_pkg::OP_LOAD_Q: begin
        held_nxt = div_quo;
      end
      lps_pkg::OP_LOAD_L1: begin
        held_nxt = l1_r;
      end
      lps_pkg::OP_LOAD_L0: begin
        held_nxt = rd_level_r;
      end
      default: ;
    endcase
  end

  assign div_go = (uw.op == lps_pkg::OP_DIV_GO);

  // Table addresses.
  assign wr_en   = (uw.op == lps_pkg::OP_WRITE) &&
                   (32'(req_r.step_index) < 32'(MAX_STEPS));
  assign wr_addr = AW'(req_r.step_index);

  always_comb begin
    unique case (uw.rd)
      lps_pkg::RD_NONE: rd_addr = '0;
      lps_pkg::RD_ZERO: rd_addr = '0;
      lps_pkg::RD_CUR:  rd_addr = slot({1'b0, cur_r});
      lps_pkg::RD_NEXT: rd_addr = slot(cur_plus1);
      default:          rd_addr = '0;
    endcase
  end

  // Step tables: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lvl_mem[wr_addr] <= req_r.step_level;
      dur_mem[wr_addr] <= req_r.step_duration;
    end
    if (uw.rd != lps_pkg::RD_NONE) begin
      rd_level_r <= lvl_mem[rd_addr];
      rd_dur_r   <= dur_mem[rd_addr];
    end
  end

  // Control and playback state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= lps_pkg::U_IDLE;
      cur_r       <= '0;
      passes_r    <= '0;
      tl_r        <= '0;
      since_r     <= '0;
      active_r    <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cur_r       <= cur_nxt;
      passes_r    <= passes_nxt;
      tl_r        <= tl_nxt;
      since_r     <= since_nxt;
      active_r    <= active_nxt;
      held_r      <= held_nxt;
      out_valid_r <= (uw.op == lps_pkg::OP_EMIT);
    end
  end

  // Item registers and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    wrote_r   <= wrote_nxt;
    overdue_r <= overdue_nxt;
    l0_r      <= l0_nxt;
    l1_r      <= l1_nxt;
    dur_r     <= dur_nxt;
    rem_r     <= rem_nxt;
    acc_r     <= acc_nxt;
    if (uw.op == lps_pkg::OP_EMIT) begin
      out_r.pwm_level     <= held_r;
      out_r.level_written <= wrote_r;
      out_r.is_playing    <= active_r;
    end
  end

  // Interpolation divider.
  lps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (acc_r),
    .den   (dur_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer testbench
// Drives table writes, start requests and millisecond ticks into the
// sequencer, predicts every result with a behavioral copy of the sequencer
// kept in step with each accepted item, and compares each result field by
// field. Directed cases come first, then random phases under changing
// register settings with random gaps between items.
// ----------------------------------------------------------------------------
module tb;

  localparam int STEPS       = lps_pkg::MAX_STEPS_DEF;
  localparam int SW          = $clog2(STEPS);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  lps_pkg::in_t  in_item;
  logic          out_valid;
  lps_pkg::out_t out_item;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [15:0]   cfg_data;

  led_pattern_sequencer_unit #(.MAX_STEPS(STEPS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted sequencer state and register copies.
  logic [7:0]  lvl_tab [STEPS];
  logic [15:0] dur_tab [STEPS];
  int unsigned cur_step;
  int unsigned passes;
  int unsigned ms_left;
  int unsigned since_refresh;
  bit          playing;
  logic [7:0]  held_level;
  logic [4:0]  steps_cfg;
  logic [7:0]  repeats_cfg;
  bit          fade_cfg;
  logic [15:0] interval_cfg;

  lps_pkg::out_t expected_levels[$];
  int            mismatches;
  int            cycles;

  // Step count as the sequencer applies it.
  function automatic int unsigned step_limit();
    if (steps_cfg == 0) return 1;
    if (steps_cfg > STEPS) return STEPS;
    return 32'(steps_cfg);
  endfunction

  function automatic logic [SW-1:0] table_slot(input int unsigned i);
    return (i < STEPS) ? SW'(i) : SW'(STEPS - 1);
  endfunction

  // Moves to the next step; returns 0 when playback stops.
  function automatic bit next_step();
    cur_step++;
    if (cur_step >= step_limit()) begin
      if (passes == repeats_cfg) begin
        playing = 1'b0;
        return 1'b0;
      end
      passes   = (passes + 1) & 8'hFF;
      cur_step = 0;
    end
    ms_left = 32'(dur_tab[table_slot(cur_step)]);
    return 1'b1;
  endfunction

  // Applies one item to the predicted state and returns its result.
  function automatic lps_pkg::out_t sequencer_next(input lps_pkg::in_t it);
    bit            wrote;
    bit            overdue;
    logic [SW-1:0] s;
    int unsigned   l0;
    int unsigned   l1;
    int unsigned   dur;
    int unsigned   rem;
    lps_pkg::out_t r;
    wrote = 1'b0;
    case (it.req_type)
      lps_pkg::REQ_WRITE: begin
        lvl_tab[it.step_index] = it.step_level;
        dur_tab[it.step_index] = it.step_duration;
      end
      lps_pkg::REQ_START: begin
        cur_step   = 0;
        passes     = 0;
        held_level = lvl_tab[0];
        ms_left    = 32'(dur_tab[0]);
        playing    = 1'b1;
        wrote      = 1'b1;
      end
      lps_pkg::REQ_TICK: begin
        if (since_refresh < 16'hFFFF) since_refresh++;
        if (playing) begin
          overdue = (ms_left == 0);
          if (!overdue) ms_left--;
          if (!fade_cfg) begin
            if (ms_left == 0 && next_step()) begin
              held_level = lvl_tab[table_slot(cur_step)];
              wrote      = 1'b1;
            end
          end else if (since_refresh >= interval_cfg) begin
            s             = table_slot(cur_step);
            since_refresh = 0;
            if (cur_step + 1 < step_limit()) begin
              l0  = 32'(lvl_tab[s]);
              l1  = 32'(lvl_tab[table_slot(cur_step + 1)]);
              dur = 32'(dur_tab[s]);
              rem = ms_left;
              if (dur == 0) begin
                held_level = l1[7:0];
              end else begin
                if (rem > dur) rem = dur;
                held_level = 8'((l0 * rem + l1 * (dur - rem)) / dur);
              end
            end else begin
              held_level = lvl_tab[s];
            end
            wrote = 1'b1;
            if (overdue) void'(next_step());
          end
        end
      end
      default: ;
    endcase
    r.pwm_level     = held_level;
    r.level_written = wrote;
    r.is_playing    = playing;
    return r;
  endfunction

  function automatic lps_pkg::in_t make_item(input logic [1:0] req, input logic [3:0] idx,
                                             input logic [7:0] lvl, input logic [15:0] dur);
    lps_pkg::in_t it;
    it.req_type      = req;
    it.step_index    = idx;
    it.step_level    = lvl;
    it.step_duration = dur;
    return it;
  endfunction

  // Mostly back-to-back or short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Durations stay short so patterns actually play through.
  function automatic logic [15:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 95) return 16'($urandom_range(1, 6));
    if (r < 97) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Sends one item and records its predicted result once it is taken.
  task automatic issue_item(input lps_pkg::in_t it, input int unsigned gap);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    expected_levels.push_back(sequencer_next(it));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result has come back.
  task automatic settle();
    start <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all four registers; bits above a register's width are ignored.
  task automatic load_config(input logic [15:0] sc, input logic [15:0] rc,
                             input logic [15:0] fe, input logic [15:0] ui);
    cfg_we <= 1'b1; cfg_index <= lps_pkg::REG_STEP_COUNT; cfg_data <= sc;
    @(posedge clk);
    steps_cfg = sc[4:0];
    cfg_index <= lps_pkg::REG_REPEAT_COUNT; cfg_data <= rc;
    @(posedge clk);
    repeats_cfg = rc[7:0];
    cfg_index <= lps_pkg::REG_FADE_ENABLE;  cfg_data <= fe;
    @(posedge clk);
    fade_cfg = fe[0];
    cfg_index <= lps_pkg::REG_UPDATE_INTVL; cfg_data <= ui;
    @(posedge clk);
    interval_cfg = ui;
    cfg_we <= 1'b0;
  endtask

  // Plain hold playback of a two-step pattern, plus idle requests.
  task automatic test_hold_playback();
    load_config(16'd2, 16'd0, 16'd0, 16'd20);
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd0, 8'd255, 16'd1), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd1, 8'd0, 16'd2), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_NONE, 4'hF, 8'hFF, 16'hFFFF), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_TICK, 4'd0, 8'd0, 16'd0), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_START, 4'd0, 8'd0, 16'd0), pick_gap(0));
    repeat (4) issue_item(make_item(lps_pkg::REQ_TICK, 4'd0, 8'd0, 16'd0), pick_gap(0));
  endtask

  // Fade with a clamped remaining time, overdue steps, a zero-length step
  // and the last step driven at its own level until playback ends.
  task automatic test_fade_cases();
    settle();
    load_config(16'd3, 16'd0, 16'd1, 16'd1);
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd0, 8'd0, 16'd3), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd1, 8'd255, 16'd0), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd2, 8'd77, 16'd2), pick_gap(0));
    issue_item(make_item(lps_pkg::REQ_START, 4'd0, 8'd0, 16'd0), pick_gap(0));
    // Shrinking the running step leaves more time than its new duration.
    issue_item(make_item(lps_pkg::REQ_WRITE, 4'd0, 8'd0, 16'd1), pick_gap(0));
    repeat (9) issue_item(make_item(lps_pkg::REQ_TICK, 4'd0, 8'd0, 16'd0), pick_gap(0));
  endtask

  // Fills the whole table so that no later read hits an unwritten entry.
  task automatic test_table_fill();
    for (int i = 0; i < STEPS; i++) begin
      issue_item(make_item(lps_pkg::REQ_WRITE, 4'(i), 8'($urandom), pick_duration()),
                 pick_gap(0));
    end
  endtask

  // Random phases: each sets the registers, starts a pattern and mostly
  // ticks, with writes, restarts and unused codes mixed in.
  task automatic test_random_phases();
    logic [15:0]  sc;
    logic [15:0]  rc;
    logic [15:0]  fe;
    logic [15:0]  ui;
    int unsigned  n;
    int unsigned  r;
    bit           calm;
    lps_pkg::in_t it;
    for (int p = 0; p < 30; p++) begin
      settle();
      case (p)
        0: begin sc = 16'd0;  rc = 16'd0;   fe = 16'd0; ui = 16'd20;    end
        1: begin sc = 16'd31; rc = 16'd255; fe = 16'd1; ui = 16'd0;     end
        2: begin sc = 16'd16; rc = 16'd1;   fe = 16'd1; ui = 16'hFFFF;  end
        3: begin sc = 16'd1;  rc = 16'd255; fe = 16'd0; ui = 16'd1;     end
        default: begin
          sc = 16'($urandom_range(0, 31));
          rc = ($urandom_range(0, 9) == 0) ? 16'd255 : 16'($urandom_range(0, 3));
          fe = 16'($urandom_range(0, 1));
          ui = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        end
      endcase
      // Upper data bits are don't-care for the narrow registers.
      load_config({11'($urandom), sc[4:0]}, {8'($urandom), rc[7:0]},
                  {15'($urandom), fe[0]}, ui);
      calm = ($urandom_range(0, 3) == 0);
      issue_item(make_item(lps_pkg::REQ_START, 4'($urandom), 8'($urandom), 16'($urandom)),
                 pick_gap(calm));
      n = $urandom_range(40, 80);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          it = make_item(lps_pkg::REQ_TICK, 4'($urandom), 8'($urandom), 16'($urandom));
        end else if (r < 84) begin
          it = make_item(lps_pkg::REQ_WRITE, 4'($urandom), 8'($urandom), pick_duration());
        end else if (r < 93) begin
          it = make_item(lps_pkg::REQ_START, 4'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          it = make_item(lps_pkg::REQ_NONE, 4'($urandom), 8'($urandom), 16'($urandom));
        end
        issue_item(it, pick_gap(calm));
      end
    end
  endtask

  // Compares each result with the oldest prediction.
  always @(posedge clk) begin : result_check
    lps_pkg::out_t want;
    if (out_valid === 1'b1) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        if (out_item.pwm_level !== want.pwm_level) begin
          $display("%0t: pwm_level expected %0d actual %0d",
                   $time, want.pwm_level, out_item.pwm_level);
          mismatches++;
        end
        if (out_item.level_written !== want.level_written) begin
          $display("%0t: level_written expected %0b actual %0b",
                   $time, want.level_written, out_item.level_written);
          mismatches++;
        end
        if (out_item.is_playing !== want.is_playing) begin
          $display("%0t: is_playing expected %0b actual %0b",
                   $time, want.is_playing, out_item.is_playing);
          mismatches++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL led_pattern_sequencer_unit");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles     = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= lps_pkg::REG_STEP_COUNT;
    cfg_data  <= '0;
    // Predicted state after reset.
    cur_step      = 0;
    passes        = 0;
    ms_left       = 0;
    since_refresh = 0;
    playing       = 1'b0;
    held_level    = 8'd0;
    steps_cfg     = 5'd1;
    repeats_cfg   = 8'd0;
    fade_cfg      = 1'b0;
    interval_cfg  = 16'd20;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hold_playback();
    test_fade_cases();
    test_table_fill();
    test_random_phases();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("PASS led_pattern_sequencer_unit");
    end else begin
      $display("FAIL led_pattern_sequencer_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lps_pkg.sv
design/lps_div.sv
design/led_pattern_sequencer_unit.sv
tb/tb.sv
